@@ hw/rtl/wve_pkg.sv @@
// ----------------------------------------------------------------------------
// wve_pkg - wheel velocity estimator package
// Opcodes, fixed-point constants, request type and output rounding helper.
// ----------------------------------------------------------------------------
package wve_pkg;

  localparam logic [1:0] OP_INIT   = 2'd0;
  localparam logic [1:0] OP_UPDATE = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  localparam logic [31:0] TICKS_PER_SECOND = 32'd1000000;
  localparam logic [63:0] MAG_CAP          = 64'h3FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic start;
    logic nodiv;
  } md_req_t;

  // Q32.32 signed -> Q16.16 signed, truncation toward zero, saturated
  function automatic logic [31:0] to_q16(input logic signed [63:0] x);
    logic        neg;
    logic [63:0] m;
    logic [47:0] m16;
    logic [31:0] r;
    neg = x[63];
    m   = neg ? (64'd0 - 64'(x)) : 64'(x);
    m16 = m[63:16];
    if (!neg && m16 > 48'h0000_7FFF_FFFF) m16 = 48'h0000_7FFF_FFFF;
    if (neg && m16 > 48'h0000_8000_0000) m16 = 48'h0000_8000_0000;
    r = neg ? (32'd0 - m16[31:0]) : m16[31:0];
    return r;
  endfunction

endpackage

@@ hw/rtl/wve_muldiv.sv @@
// ----------------------------------------------------------------------------
// wve_muldiv - shared multiply / divide unit
// min(floor(a*b/d), cap) via two 32x32 partial products and a radix-4 divider, or a*b (low 64 bits) when nodiv.
// ----------------------------------------------------------------------------
module wve_muldiv import wve_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  md_req_t     req,
  input  logic [63:0] a,
  input  logic [31:0] b,
  input  logic [31:0] d,
  output logic        done,
  output logic [63:0] q
);

  localparam logic [2:0] MD_IDLE = 3'd0;
  localparam logic [2:0] MD_LO   = 3'd1;
  localparam logic [2:0] MD_HI   = 3'd2;
  localparam logic [2:0] MD_CHK  = 3'd3;
  localparam logic [2:0] MD_DIV  = 3'd4;

  logic [2:0]  state;
  logic        nodiv;
  logic [63:0] a_r;
  logic [31:0] b_r;
  logic [31:0] d_r;
  logic [63:0] p0;
  logic [63:0] p1;
  logic [31:0] rem;
  logic [63:0] dvd;
  logic [4:0]  cnt;

  logic [32:0] r1, s1, r2, s2;
  logic        ge1, ge2;

  // two restoring steps per cycle
  always_comb begin
    r1  = {rem, dvd[63]};
    ge1 = r1 >= {1'b0, d_r};
    s1  = ge1 ? (r1 - {1'b0, d_r}) : r1;
    r2  = {s1[31:0], dvd[62]};
    ge2 = r2 >= {1'b0, d_r};
    s2  = ge2 ? (r2 - {1'b0, d_r}) : r2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MD_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        MD_IDLE: begin
          if (req.start) begin
            nodiv <= req.nodiv;
            a_r   <= a;
            b_r   <= b;
            d_r   <= d;
            state <= MD_LO;
          end
        end
        MD_LO: begin
          p0    <= 64'(a_r[31:0]) * 64'(b_r);
          state <= MD_HI;
        end
        MD_HI: begin
          p1    <= 64'(a_r[63:32]) * 64'(b_r) + {32'd0, p0[63:32]};
          state <= MD_CHK;
        end
        MD_CHK: begin
          if (nodiv) begin
            q     <= {p1[31:0], p0[31:0]};
            done  <= 1'b1;
            state <= MD_IDLE;
          end else if (p1[63:32] >= d_r) begin
            // quotient needs more than 64 bits
            q     <= MAG_CAP;
            done  <= 1'b1;
            state <= MD_IDLE;
          end else begin
            rem   <= p1[63:32];
            dvd   <= {p1[31:0], p0[31:0]};
            cnt   <= 5'd0;
            state <= MD_DIV;
          end
        end
        MD_DIV: begin
          rem <= s2[31:0];
          dvd <= {dvd[61:0], ge1, ge2};
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            q     <= ({dvd[61:0], ge1, ge2} > MAG_CAP) ? MAG_CAP : {dvd[61:0], ge1, ge2};
            done  <= 1'b1;
            state <= MD_IDLE;
          end
        end
        default: state <= MD_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/wheel_velocity_estimator.sv @@
// ----------------------------------------------------------------------------
// wheel_velocity_estimator - finite difference wheel speed estimator
// Three-slot sample history, rates, acceleration and velocity in fixed point.
// ----------------------------------------------------------------------------
// channel | signals                                       | dir
// in      | in_valid in_ready opcode sample_time encoder_count | in beat
// out     | out_valid out_ready velocity acceleration      | out beat
// cfg     | cfg_wr_en cfg_wr_data (metres_per_tick)       | write only
//
// Init, update and unused opcodes: straight from idle to the output state.
// Query: steps run on the shared muldiv unit: two multiply passes and
//   four divides (2 bits a cycle); a divide with a zero time difference
//   is skipped and its result is zero.
// One item at a time; in_ready only in idle. A pending out beat stalls the
//   next result, not the next in beat. Reset: synchronous, clears history.
// ----------------------------------------------------------------------------
module wheel_velocity_estimator import wve_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         opcode,
  input  logic [31:0]        sample_time,
  input  logic [31:0]        encoder_count,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] velocity,
  output logic signed [31:0] acceleration,
  input  logic               cfg_wr_en,
  input  logic [31:0]        cfg_wr_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_R1M  = 3'd1;  // |dc1| * metres_per_tick
  localparam logic [2:0] ST_R1D  = 3'd2;  // * ticks / dus1
  localparam logic [2:0] ST_R2M  = 3'd3;
  localparam logic [2:0] ST_R2D  = 3'd4;
  localparam logic [2:0] ST_ACC  = 3'd5;  // (r2 - r1) * ticks / dus2
  localparam logic [2:0] ST_VEL  = 3'd6;  // |acc| * dq / ticks
  localparam logic [2:0] ST_OUT  = 3'd7;

  logic [2:0]  state;
  logic        issued;
  logic [31:0] times [3];
  logic [31:0] counts [3];
  logic [31:0] mpt;
  logic [1:0]  op_q;
  logic [31:0] t_q;
  logic [63:0] m_q;
  logic signed [63:0] r1, r2, acc, vel;

  md_req_t     md_req;
  logic [63:0] md_a;
  logic [31:0] md_b, md_d;
  logic        md_done;
  logic [63:0] md_q;

  // differences between slots, and from the newest slot to the query time
  logic [31:0] dus1, dus2, dq;
  logic        neg1, neg2, negd, nega;
  logic [31:0] dc1, dc2;
  logic signed [63:0] diff;
  logic [63:0] magd, maga;
  logic        skip, compute;

  always_comb begin
    dus1 = times[1] - times[0];
    dus2 = times[2] - times[1];
    dq   = t_q - times[2];
    neg1 = counts[1] < counts[0];
    neg2 = counts[2] < counts[1];
    dc1  = neg1 ? (counts[0] - counts[1]) : (counts[1] - counts[0]);
    dc2  = neg2 ? (counts[1] - counts[2]) : (counts[2] - counts[1]);
    diff = r2 - r1;
    negd = diff[63];
    magd = negd ? (64'd0 - 64'(diff)) : 64'(diff);
    nega = acc[63];
    maga = nega ? (64'd0 - 64'(acc)) : 64'(acc);
  end

  // operand select for the shared unit
  always_comb begin
    md_a         = m_q;
    md_b         = TICKS_PER_SECOND;
    md_d         = dus1;
    md_req.nodiv = 1'b0;
    skip         = 1'b0;
    compute      = 1'b1;
    case (state)
      ST_R1M: begin
        md_a         = {32'd0, dc1};
        md_b         = mpt;
        md_req.nodiv = 1'b1;
      end
      ST_R1D: begin
        md_d = dus1;
        skip = (dus1 == 32'd0);
      end
      ST_R2M: begin
        md_a         = {32'd0, dc2};
        md_b         = mpt;
        md_req.nodiv = 1'b1;
      end
      ST_R2D: begin
        md_d = dus2;
        skip = (dus2 == 32'd0);
      end
      ST_ACC: begin
        md_a = magd;
        md_d = dus2;
        skip = (dus2 == 32'd0);
      end
      ST_VEL: begin
        md_a = maga;
        md_b = dq;
        md_d = TICKS_PER_SECOND;
      end
      default: compute = 1'b0;
    endcase
    md_req.start = compute && !issued && !skip;
  end

  wve_muldiv u_muldiv (
    .clk  (clk),
    .rst  (rst),
    .req  (md_req),
    .a    (md_a),
    .b    (md_b),
    .d    (md_d),
    .done (md_done),
    .q    (md_q)
  );

  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      issued    <= 1'b0;
      out_valid <= 1'b0;
      mpt       <= 32'd0;
      for (int i = 0; i < 3; i++) begin
        times[i]  <= 32'd0;
        counts[i] <= 32'd0;
      end
    end else begin
      if (cfg_wr_en) mpt <= cfg_wr_data;
      // ST_OUT drives out_valid itself
      if (out_valid && out_ready && state != ST_OUT) out_valid <= 1'b0;
      if (compute && !issued && !skip) issued <= 1'b1;
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            op_q <= opcode;
            t_q  <= sample_time;
            if (opcode == OP_INIT) begin
              for (int i = 0; i < 3; i++) begin
                times[i]  <= sample_time;
                counts[i] <= encoder_count;
              end
            end else if (opcode == OP_UPDATE) begin
              times[0]  <= times[1];
              counts[0] <= counts[1];
              times[1]  <= times[2];
              counts[1] <= counts[2];
              times[2]  <= sample_time;
              counts[2] <= encoder_count;
            end
            state <= (opcode == OP_QUERY) ? ST_R1M : ST_OUT;
          end
        end
        ST_R1M, ST_R2M: begin
          if (md_done) begin
            m_q    <= md_q;
            issued <= 1'b0;
            state  <= state + 3'd1;
          end
        end
        ST_R1D: begin
          if (skip) begin
            r1    <= 64'sd0;
            state <= ST_R2M;
          end else if (md_done) begin
            r1     <= neg1 ? -$signed(md_q) : $signed(md_q);
            issued <= 1'b0;
            state  <= ST_R2M;
          end
        end
        ST_R2D: begin
          if (skip) begin
            r2    <= 64'sd0;
            state <= ST_ACC;
          end else if (md_done) begin
            r2     <= neg2 ? -$signed(md_q) : $signed(md_q);
            issued <= 1'b0;
            state  <= ST_ACC;
          end
        end
        ST_ACC: begin
          if (skip) begin
            acc   <= 64'sd0;
            state <= ST_VEL;
          end else if (md_done) begin
            acc    <= negd ? -$signed(md_q) : $signed(md_q);
            issued <= 1'b0;
            state  <= ST_VEL;
          end
        end
        ST_VEL: begin
          if (md_done) begin
            vel    <= r2 + (nega ? -$signed(md_q) : $signed(md_q));
            issued <= 1'b0;
            state  <= ST_OUT;
          end
        end
        ST_OUT: begin
          // hold the result until the out register is free
          if (!out_valid || out_ready) begin
            if (op_q == OP_QUERY) begin
              velocity     <= $signed(to_q16(vel));
              acceleration <= $signed(to_q16(acc));
            end else begin
              velocity     <= 32'sd0;
              acceleration <= 32'sd0;
            end
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_start_in_compute: assert property (@(posedge clk) disable iff (rst)
    md_req.start |-> (state != ST_IDLE && state != ST_OUT))
    else $error("muldiv started outside a compute step");
  a_done_issued: assert property (@(posedge clk) disable iff (rst)
    md_done |-> issued)
    else $error("muldiv done with no request outstanding");
  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in beat taken while busy");
  a_query_path: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && opcode == OP_QUERY) |=> (state == ST_R1M))
    else $error("query did not start the rate sequence");
`endif

endmodule
